[hw/rtl/assert_macros.svh]
// assertion helpers included by the sort top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define CSK_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("csk: assertion failed");

// condition on one edge implies a consequence on the next edge
`define CSK_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("csk: assertion failed");

`endif

[hw/rtl/csk_pkg.sv]
package csk_pkg;

  localparam int unsigned KEY_W  = 4;
  localparam int unsigned SLOT_W = 5;
  localparam int unsigned CNT_W  = 6;

  localparam int unsigned KEY_MAX_DEF   = 9;
  localparam int unsigned MAX_ITEMS_DEF = 32;

endpackage

[hw/rtl/csk_ram.sv]
module csk_ram #(
  parameter int unsigned Depth = 32,
  parameter int unsigned Width = 4,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // write-first: a read of the entry being written returns the new word
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/counting_sort_small_keys_top.sv]
// channel  dir  handshake                payload
// in       in   in_valid_i/in_stall_o    key_i, last_item_i
// out      out  out_valid_o/out_stall_i  sorted_key_o, dest_slot_o, last_result_o, overflowed_o
// loading takes one word a cycle; the bucket read-modify-write forwards through the ram
// after the last word: prefix pass over buckets 0..KeyMax, a sort walk over the n words, then
// n results at up to one a cycle while out_stall_i is low, then a bucket clearing pass
// reset starts with the same clearing pass; in_stall_o stays high outside loading
// a stalled result holds in the ram read registers while the next set loads
`include "assert_macros.svh"

module counting_sort_small_keys_top #(
  parameter int unsigned KeyMax   = csk_pkg::KEY_MAX_DEF,
  parameter int unsigned MaxItems = csk_pkg::MAX_ITEMS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [csk_pkg::KEY_W-1:0]  key_i,
  input  logic                       last_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [csk_pkg::KEY_W-1:0]  sorted_key_o,
  output logic [csk_pkg::SLOT_W-1:0] dest_slot_o,
  output logic                       last_result_o,
  output logic                       overflowed_o
);

  import csk_pkg::*;

  localparam int unsigned BW = $clog2(KeyMax + 1);
  localparam int unsigned AW = $clog2(MaxItems);
  localparam int unsigned CW = $clog2(MaxItems + 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_LOAD,
    ST_PREFIX,
    ST_SORT,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  logic              ld_vld_q, ld_vld_d;
  logic [BW-1:0]     ld_key_q, ld_key_d;
  logic [CW-1:0]     item_cnt_q, item_cnt_d;
  logic              ovf_q, ovf_d;
  logic [BW-1:0]     p_cnt_q, p_cnt_d;
  logic              p_done_q, p_done_d;
  logic              pf_vld_q, pf_vld_d;
  logic [BW-1:0]     pf_addr_q, pf_addr_d;
  logic [CNT_W-1:0]  acc_q, acc_d;
  logic [CW-1:0]     s_cnt_q, s_cnt_d;
  logic              s1_vld_q, s1_vld_d;
  logic [AW-1:0]     s1_idx_q, s1_idx_d;
  logic              s2_vld_q, s2_vld_d;
  logic [AW-1:0]     s2_idx_q, s2_idx_d;
  logic [KEY_W-1:0]  s2_key_q, s2_key_d;
  logic [CW-1:0]     e_cnt_q, e_cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              last_q, last_d;
  logic              ovf_out_q, ovf_out_d;

  logic              in_acc, full, pf_iss, s_iss, e_iss, e_last;
  logic [KEY_W-1:0]  key_sat;
  logic [CNT_W-1:0]  sum, end_raw, end_cl;

  logic              b_we, b_re;
  logic [BW-1:0]     b_waddr, b_raddr;
  logic [CNT_W-1:0]  b_wdata, b_rdata;
  logic [KEY_W-1:0]  k_rdata;

  assign in_acc  = in_valid_i && (state_q == ST_LOAD);
  assign full    = (item_cnt_q == CW'(MaxItems));
  assign key_sat = (int'(key_i) > KeyMax) ? KEY_W'(KeyMax) : key_i;

  assign pf_iss = (state_q == ST_PREFIX) && !p_done_q;
  assign s_iss  = (state_q == ST_SORT) && (s_cnt_q != item_cnt_q);
  assign e_iss  = (state_q == ST_EMIT) && (e_cnt_q != item_cnt_q)
                  && (!out_valid_q || !out_stall_i);
  assign e_last = (CW'(e_cnt_q + 1'b1) == item_cnt_q);

  assign sum     = acc_q + b_rdata;
  // an empty bucket counts as zero, so its end stays at slot zero
  assign end_raw = (b_rdata == '0) ? '0 : b_rdata - 1'b1;
  assign end_cl  = (int'(end_raw) >= MaxItems) ? CNT_W'(MaxItems - 1) : end_raw;

  // bucket port: one phase drives it at a time
  always_comb begin
    b_we    = 1'b0;
    b_waddr = '0;
    b_wdata = '0;
    b_re    = 1'b0;
    b_raddr = '0;
    if (state_q == ST_CLEAR) begin
      b_we    = 1'b1;
      b_waddr = p_cnt_q;
    end
    if (ld_vld_q) begin
      b_we    = 1'b1;
      b_waddr = ld_key_q;
      b_wdata = b_rdata + 1'b1;
    end
    if (pf_vld_q) begin
      b_we    = 1'b1;
      b_waddr = pf_addr_q;
      b_wdata = sum;
    end
    if (s2_vld_q) begin
      b_we    = 1'b1;
      b_waddr = BW'(s2_key_q);
      b_wdata = end_cl;
    end
    if (in_acc && !full) begin
      b_re    = 1'b1;
      b_raddr = BW'(key_sat);
    end
    if (pf_iss) begin
      b_re    = 1'b1;
      b_raddr = p_cnt_q;
    end
    if (s1_vld_q) begin
      b_re    = 1'b1;
      b_raddr = BW'(k_rdata);
    end
  end

  csk_ram #(
    .Depth (KeyMax + 1),
    .Width (CNT_W),
    .AddrW (BW)
  ) u_bucket_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .re_i    (b_re),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  csk_ram #(
    .Depth (MaxItems),
    .Width (KEY_W),
    .AddrW (AW)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && !full),
    .waddr_i (item_cnt_q[AW-1:0]),
    .wdata_i (key_sat),
    .re_i    (s_iss),
    .raddr_i (s_cnt_q[AW-1:0]),
    .rdata_o (k_rdata)
  );

  csk_ram #(
    .Depth (MaxItems),
    .Width (KEY_W),
    .AddrW (AW)
  ) u_sorted_ram (
    .clk_i   (clk_i),
    .we_i    (s2_vld_q),
    .waddr_i (end_cl[AW-1:0]),
    .wdata_i (s2_key_q),
    .re_i    (e_iss),
    .raddr_i (e_cnt_q[AW-1:0]),
    .rdata_o (sorted_key_o)
  );

  csk_ram #(
    .Depth (MaxItems),
    .Width (SLOT_W),
    .AddrW (AW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (s2_vld_q),
    .waddr_i (s2_idx_q),
    .wdata_i (end_cl[SLOT_W-1:0]),
    .re_i    (e_iss),
    .raddr_i (e_cnt_q[AW-1:0]),
    .rdata_o (dest_slot_o)
  );

  always_comb begin
    state_d     = state_q;
    item_cnt_d  = item_cnt_q;
    ovf_d       = ovf_q;
    p_cnt_d     = p_cnt_q;
    p_done_d    = p_done_q;
    acc_d       = acc_q;
    s_cnt_d     = s_cnt_q;
    e_cnt_d     = e_cnt_q;
    last_d      = last_q;
    ovf_out_d   = ovf_out_q;

    ld_vld_d    = in_acc && !full;
    ld_key_d    = BW'(key_sat);
    pf_vld_d    = pf_iss;
    pf_addr_d   = p_cnt_q;
    s1_vld_d    = s_iss;
    s1_idx_d    = s_cnt_q[AW-1:0];
    s2_vld_d    = s1_vld_q;
    s2_idx_d    = s1_idx_q;
    s2_key_d    = k_rdata;
    out_valid_d = e_iss || (out_valid_q && out_stall_i);

    unique case (state_q)
      ST_CLEAR: begin
        if (p_cnt_q == BW'(KeyMax)) begin
          state_d = ST_LOAD;
        end else begin
          p_cnt_d = p_cnt_q + 1'b1;
        end
      end
      ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            item_cnt_d = item_cnt_q + 1'b1;
          end
          if (last_item_i) begin
            state_d  = ST_PREFIX;
            p_cnt_d  = '0;
            p_done_d = 1'b0;
            acc_d    = '0;
          end
        end
      end
      ST_PREFIX: begin
        if (pf_iss) begin
          if (p_cnt_q == BW'(KeyMax)) begin
            p_done_d = 1'b1;
          end else begin
            p_cnt_d = p_cnt_q + 1'b1;
          end
        end
        if (pf_vld_q) begin
          acc_d = sum;
        end
        if (p_done_q && !pf_vld_q) begin
          state_d = ST_SORT;
          s_cnt_d = '0;
        end
      end
      ST_SORT: begin
        if (s_iss) begin
          s_cnt_d = s_cnt_q + 1'b1;
        end else if (!s1_vld_q && !s2_vld_q) begin
          state_d = ST_EMIT;
          e_cnt_d = '0;
        end
      end
      ST_EMIT: begin
        if (e_iss) begin
          e_cnt_d   = e_cnt_q + 1'b1;
          last_d    = e_last;
          ovf_out_d = ovf_q;
          if (e_last) begin
            state_d    = ST_CLEAR;
            p_cnt_d    = '0;
            item_cnt_d = '0;
            ovf_d      = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_CLEAR;
        p_cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ld_vld_q    <= 1'b0;
      ld_key_q    <= '0;
      item_cnt_q  <= '0;
      ovf_q       <= 1'b0;
      p_cnt_q     <= '0;
      p_done_q    <= 1'b0;
      pf_vld_q    <= 1'b0;
      pf_addr_q   <= '0;
      acc_q       <= '0;
      s_cnt_q     <= '0;
      s1_vld_q    <= 1'b0;
      s1_idx_q    <= '0;
      s2_vld_q    <= 1'b0;
      s2_idx_q    <= '0;
      s2_key_q    <= '0;
      e_cnt_q     <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      ovf_out_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      ld_vld_q    <= ld_vld_d;
      ld_key_q    <= ld_key_d;
      item_cnt_q  <= item_cnt_d;
      ovf_q       <= ovf_d;
      p_cnt_q     <= p_cnt_d;
      p_done_q    <= p_done_d;
      pf_vld_q    <= pf_vld_d;
      pf_addr_q   <= pf_addr_d;
      acc_q       <= acc_d;
      s_cnt_q     <= s_cnt_d;
      s1_vld_q    <= s1_vld_d;
      s1_idx_q    <= s1_idx_d;
      s2_vld_q    <= s2_vld_d;
      s2_idx_q    <= s2_idx_d;
      s2_key_q    <= s2_key_d;
      e_cnt_q     <= e_cnt_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
      ovf_out_q   <= ovf_out_d;
    end
  end

  assign in_stall_o    = (state_q != ST_LOAD);
  assign out_valid_o   = out_valid_q;
  assign last_result_o = last_q;
  assign overflowed_o  = ovf_out_q;

  // no prefix or sort traffic while words are being taken
  `CSK_ASSERT(a_load_quiet, in_stall_o || (!pf_vld_q && !s1_vld_q && !s2_vld_q))
  // the trailing load update never shares the write port with the prefix pass
  `CSK_ASSERT(a_wr_port_excl, !(ld_vld_q && pf_vld_q))
  `CSK_ASSERT(a_count_bound, int'(item_cnt_q) <= MaxItems)
  `CSK_ASSERT(a_out_from_emit, !$rose(out_valid_o) || $past(state_q == ST_EMIT))
  // leaving the emit phase means the final result of the set is on show
  `CSK_ASSERT_NEXT(a_last_shown, (state_q == ST_EMIT) && (state_d == ST_CLEAR),
                   out_valid_o && last_result_o)

endmodule
